// File: rtl/core/mts_pkg.sv
package mts_pkg;

    localparam int DATA_W     = 32;
    localparam int MODE_W     = 2;
    localparam int CAP_W      = 7;
    localparam int STAT_W     = 2;
    localparam int OUT_DATA_W = 3 * DATA_W;
    localparam int OUT_USER_W = STAT_W + 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

// File: rtl/core/mts_ram.sv
module mts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/min_tracking_stack.sv
// channel  | ports                          | contents (low bits first)
// s_ in    | s_tvalid s_tready s_tdata/user | tdata: push_value; tuser: mode
// m_ out   | m_tvalid m_tready m_tdata/user | tdata: popped, top, min;
//          |                                | tuser: is_empty, is_full, status
// cfg      | cfg_wr_en cfg_wr_data          | capacity
// push, query and refused requests give their result in the cycle after acceptance
// a successful pop passes through ST_POP: the new tops come from registered reads of
// the value and minimum memories, and no request is taken while in ST_POP
// reset clears both counts and sets capacity to 64; memories are not cleared
// the input stalls while a result sits in the output register untaken
module min_tracking_stack #(
    parameter int DEPTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mts_pkg::CAP_W-1:0]          cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mts_pkg::DATA_W-1:0]         s_tdata,  // push_value
    input  logic [mts_pkg::MODE_W-1:0]         s_tuser,  // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mts_pkg::OUT_DATA_W-1:0]     m_tdata,  // popped_value, top_value, min_value
    output logic [mts_pkg::OUT_USER_W-1:0]     m_tuser   // is_empty, is_full, status
);
    import mts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           min_count_reg, min_count_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] min_top_reg, min_top_next;
    logic [DATA_W-1:0]       popped_reg, popped_next;
    logic                    min_pop_reg, min_pop_next;
    logic [CAP_W-1:0]        capacity_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0]   out_user_reg, out_user_next;

    logic                    val_we, min_we;
    logic [AW-1:0]           val_waddr, min_waddr, val_raddr, min_raddr;
    logic signed [DATA_W-1:0] push_val;
    logic [DATA_W-1:0]       val_rdata, min_rdata;
    logic [CW-1:0]           cnt_m2, min_cnt_m2;
    logic [XW-1:0]           cap_wide, cap_use;
    logic                    out_free, accept;
    logic                    res_load;
    logic [STAT_W-1:0]       res_status;
    logic [DATA_W-1:0]       res_popped, res_top, res_min;

    mts_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_val_ram (
        .clk   (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (s_tdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    mts_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_min_ram (
        .clk   (aclk),
        .we    (min_we),
        .waddr (min_waddr),
        .wdata (s_tdata),
        .raddr (min_raddr),
        .rdata (min_rdata)
    );

    assign push_val   = signed'(s_tdata);
    assign cnt_m2     = count_reg - CW'(2);
    assign min_cnt_m2 = min_count_reg - CW'(2);
    assign val_raddr  = cnt_m2[AW-1:0];
    assign min_raddr  = min_cnt_m2[AW-1:0];
    assign val_waddr  = count_reg[AW-1:0];
    assign min_waddr  = min_count_reg[AW-1:0];

    assign cap_wide = XW'(capacity_reg);
    assign cap_use  = (cap_wide == '0) ? XW'(1) :
                      (cap_wide > XW'(DEPTH)) ? XW'(DEPTH) : cap_wide;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        min_count_next = min_count_reg;
        top_next       = top_reg;
        min_top_next   = min_top_reg;
        popped_next    = popped_reg;
        min_pop_next   = min_pop_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        val_we         = 1'b0;
        min_we         = 1'b0;
        res_load       = 1'b0;
        res_status     = STAT_OK;
        res_popped     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_load = 1'b1;
                    case (s_tuser)
                        MODE_PUSH: begin
                            if (XW'(count_reg) >= cap_use) begin
                                res_status = STAT_FULL;
                            end else begin
                                val_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                top_next   = push_val;
                                if ((min_count_reg == '0 || push_val <= min_top_reg) &&
                                    min_count_reg < CW'(DEPTH)) begin
                                    min_we         = 1'b1;
                                    min_count_next = min_count_reg + CW'(1);
                                    min_top_next   = push_val;
                                end
                            end
                        end
                        MODE_POP: begin
                            if (count_reg == '0) begin
                                res_status = STAT_EMPTY;
                            end else begin
                                res_load     = 1'b0;
                                popped_next  = top_reg;
                                count_next   = count_reg - CW'(1);
                                min_pop_next = 1'b0;
                                if (min_count_reg != '0 && top_reg == min_top_reg) begin
                                    min_count_next = min_count_reg - CW'(1);
                                    min_pop_next   = 1'b1;
                                end
                                state_next = ST_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                // new tops come from the memory reads issued at acceptance
                top_next = signed'(val_rdata);
                if (min_pop_reg) begin
                    min_top_next = signed'(min_rdata);
                end
                res_load   = 1'b1;
                res_popped = popped_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res_top = (count_next != '0) ? top_next : '0;
        res_min = (count_next != '0 && min_count_next != '0) ? min_top_next : '0;
        if (res_load) begin
            m_valid_next  = 1'b1;
            out_data_next = {res_min, res_top, res_popped};
            out_user_next = {res_status, XW'(count_next) >= cap_use, count_next == '0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            min_count_reg <= '0;
            capacity_reg  <= CAP_RESET;
            m_valid_reg   <= 1'b0;
            min_pop_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_count_reg <= min_count_next;
            m_valid_reg   <= m_valid_next;
            min_pop_reg   <= min_pop_next;
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        min_top_reg  <= min_top_next;
        popped_reg   <= popped_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

// File: rtl/core/mts_checker.sv
module mts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mts_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [mts_pkg::OUT_USER_W-1:0] m_tuser
);
    import mts_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // empty stack reads zero top and minimum
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[OUT_DATA_W-1:DATA_W] == '0)
        else $error("empty stack shows nonzero top or minimum");

    // refused pop leaves an empty stack and pops nothing
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[OUT_USER_W-1:2] == STAT_EMPTY
        |-> m_tuser[0] && m_tdata[DATA_W-1:0] == '0)
        else $error("pop on empty with inconsistent result");

    // refused push means the stack is full and not empty
    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[OUT_USER_W-1:2] == STAT_FULL |-> m_tuser[1] && !m_tuser[0])
        else $error("push refused while not full");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);
